FILE: rtl/asrp_pkg.sv
// Shared types and constants for the ASCII sensor record parser.
`default_nettype none
package asrp_pkg;

  localparam int unsigned MaxFieldChars = 20;
  localparam int unsigned CharCntW      = 5;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChGyro    = 8'h47;
  localparam logic [7:0] ChAccel   = 8'h41;
  localparam logic [7:0] ChCompass = 8'h43;
  localparam logic [7:0] ChSystem  = 8'h44;

  localparam logic [31:0] MagLimit = 32'h8000_0000;
  localparam logic [31:0] PosMax   = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_GYRO    = 2'd0,
    KIND_ACCEL   = 2'd1,
    KIND_COMPASS = 2'd2,
    KIND_SYSTEM  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NL     = 2'd1,
    PH_FIELDS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_SKIP   = 2'd0,
    ST_SIGN   = 2'd1,
    ST_DIGITS = 2'd2,
    ST_DONE   = 2'd3
  } stage_t;

  // Per-field number parsing state.
  typedef struct packed {
    stage_t      stage;
    logic        neg;
    logic        sat;
    logic [31:0] acc;
  } fld_t;

  localparam fld_t FldClear = '{stage: ST_SKIP, neg: 1'b0, sat: 1'b0, acc: 32'd0};

endpackage
`default_nettype wire

FILE: rtl/ascii_sensor_record_parser_core.sv
// Top level of the ASCII sensor record parser.
// Takes one received character per beat and emits one beat per newline-terminated field
// of a G/A/C/D record (letter, newline, then newline-terminated decimal fields).
// Every input beat is handled in the cycle it is accepted: the record state and
// the multiply-by-ten accumulator update at that edge and a finished field lands
// in the output register, so throughput is one character per clock while in_ready
// is high. A result appears on out_* in the cycle after its terminating newline is
// accepted; in_ready stays high while the output register is empty or being drained.
`default_nettype none
module ascii_sensor_record_parser_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_sensor_kind,
  output logic [1:0]              out_field_index,
  output logic signed [31:0]      out_field_value,
  output logic                    out_record_last
);

  asrp_pkg::phase_t                 phase_r, phase_nxt;
  asrp_pkg::kind_t                  kind_r, kind_nxt;
  logic [1:0]                       fcnt_r, fcnt_nxt;
  logic [asrp_pkg::CharCntW-1:0]    ccnt_r, ccnt_nxt;
  asrp_pkg::fld_t                   fld_r, fld_nxt;
  asrp_pkg::fld_t                   fld_step;
  logic signed [31:0]               fld_value;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [1:0]  out_idx_r;
  logic [31:0] out_value_r;
  logic        out_last_r;

  logic        accept;
  logic        emit;
  logic        last;
  logic [1:0]  nfields;
  logic [2:0]  fcnt_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  asrp_field_parse u_parse (
    .ch      (in_rx_byte),
    .fld     (fld_r),
    .fld_nxt (fld_step),
    .value   (fld_value)
  );

  assign nfields  = (kind_r == asrp_pkg::KIND_SYSTEM) ? 2'd2 : 2'd3;
  assign fcnt_inc = {1'b0, fcnt_r} + 3'd1;
  assign last     = (fcnt_inc >= {1'b0, nfields});

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    fcnt_nxt  = fcnt_r;
    ccnt_nxt  = ccnt_r;
    fld_nxt   = fld_r;
    emit      = 1'b0;
    unique case (phase_r)
      asrp_pkg::PH_NL: begin
        if (in_rx_byte == asrp_pkg::ChNewline) begin
          phase_nxt = asrp_pkg::PH_FIELDS;
          fcnt_nxt  = 2'd0;
          ccnt_nxt  = '0;
          fld_nxt   = asrp_pkg::FldClear;
        end else begin
          phase_nxt = asrp_pkg::PH_IDLE;
        end
      end
      asrp_pkg::PH_FIELDS: begin
        if (in_rx_byte == asrp_pkg::ChNewline) begin
          emit = 1'b1;
        end else begin
          fld_nxt  = fld_step;
          ccnt_nxt = ccnt_r + asrp_pkg::CharCntW'(1);
        end
        // newline or over-long field: move to the next field
        if (emit || (ccnt_nxt >= asrp_pkg::CharCntW'(asrp_pkg::MaxFieldChars))) begin
          ccnt_nxt = '0;
          fld_nxt  = asrp_pkg::FldClear;
          if (last) begin
            phase_nxt = asrp_pkg::PH_IDLE;
            fcnt_nxt  = 2'd0;
          end else begin
            fcnt_nxt  = fcnt_inc[1:0];
          end
        end
      end
      default: begin
        phase_nxt = asrp_pkg::PH_IDLE;
        priority if (in_rx_byte == asrp_pkg::ChGyro) begin
          kind_nxt  = asrp_pkg::KIND_GYRO;
          phase_nxt = asrp_pkg::PH_NL;
        end else if (in_rx_byte == asrp_pkg::ChAccel) begin
          kind_nxt  = asrp_pkg::KIND_ACCEL;
          phase_nxt = asrp_pkg::PH_NL;
        end else if (in_rx_byte == asrp_pkg::ChCompass) begin
          kind_nxt  = asrp_pkg::KIND_COMPASS;
          phase_nxt = asrp_pkg::PH_NL;
        end else if (in_rx_byte == asrp_pkg::ChSystem) begin
          kind_nxt  = asrp_pkg::KIND_SYSTEM;
          phase_nxt = asrp_pkg::PH_NL;
        end else begin
          phase_nxt = asrp_pkg::PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= asrp_pkg::PH_IDLE;
      kind_r  <= asrp_pkg::KIND_GYRO;
      fcnt_r  <= 2'd0;
      ccnt_r  <= '0;
      fld_r   <= asrp_pkg::FldClear;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      fcnt_r  <= fcnt_nxt;
      ccnt_r  <= ccnt_nxt;
      fld_r   <= fld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind_r  <= kind_r;
      out_idx_r   <= fcnt_r;
      out_value_r <= fld_value;
      out_last_r  <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sensor_kind = out_kind_r;
  assign out_field_index = out_idx_r;
  assign out_field_value = signed'(out_value_r);
  assign out_record_last = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/asrp_field_parse.sv
// Decimal field parser: one character step and the saturated field value.
`default_nettype none
module asrp_field_parse (
  input  wire logic [7:0]    ch,
  input  wire asrp_pkg::fld_t fld,
  output asrp_pkg::fld_t     fld_nxt,
  output logic signed [31:0] value
);

  logic        is_digit;
  logic        is_blank;
  logic        is_sign;
  logic        do_acc;
  logic [35:0] prod;
  logic [3:0]  dig;

  assign is_digit = (ch >= asrp_pkg::ChZero) && (ch <= asrp_pkg::ChNine);
  assign is_blank = (ch == asrp_pkg::ChSpace) ||
                    ((ch >= asrp_pkg::ChTab) && (ch <= asrp_pkg::ChCr));
  assign is_sign  = (ch == asrp_pkg::ChPlus) || (ch == asrp_pkg::ChMinus);
  assign dig      = 4'(ch - asrp_pkg::ChZero);

  // acc * 10 + digit as shift-add
  assign prod = {1'b0, fld.acc, 3'b000} + {3'b000, fld.acc, 1'b0} + {32'd0, dig};

  always_comb begin
    fld_nxt = fld;
    do_acc  = 1'b0;
    unique case (fld.stage)
      asrp_pkg::ST_SKIP: begin
        if (is_blank) begin
          fld_nxt.stage = asrp_pkg::ST_SKIP;
        end else if (is_sign) begin
          fld_nxt.neg   = (ch == asrp_pkg::ChMinus);
          fld_nxt.stage = asrp_pkg::ST_SIGN;
        end else if (is_digit) begin
          fld_nxt.stage = asrp_pkg::ST_DIGITS;
          do_acc        = 1'b1;
        end else begin
          fld_nxt.stage = asrp_pkg::ST_DONE;
        end
      end
      asrp_pkg::ST_SIGN, asrp_pkg::ST_DIGITS: begin
        if (is_digit) begin
          fld_nxt.stage = asrp_pkg::ST_DIGITS;
          do_acc        = 1'b1;
        end else begin
          fld_nxt.stage = asrp_pkg::ST_DONE;
        end
      end
      default: fld_nxt.stage = asrp_pkg::ST_DONE;
    endcase

    if (do_acc && !fld.sat) begin
      if (prod > {4'd0, asrp_pkg::MagLimit}) begin
        fld_nxt.sat = 1'b1;
        fld_nxt.acc = asrp_pkg::MagLimit;
      end else begin
        fld_nxt.acc = prod[31:0];
      end
    end
  end

  always_comb begin
    if (fld.neg) begin
      if (fld.sat || (fld.acc >= asrp_pkg::MagLimit)) value = signed'(asrp_pkg::MagLimit);
      else                                           value = signed'(32'd0 - fld.acc);
    end else begin
      if (fld.sat || (fld.acc > asrp_pkg::PosMax)) value = signed'(asrp_pkg::PosMax);
      else                                        value = signed'(fld.acc);
    end
  end

endmodule
`default_nettype wire
